/* rtl/core/rqsc_pkg.sv */
// rqsc_pkg: shared types and constants for the RFID Q slot controller.
// Holds command and slot outcome codes, up/down codes and reset values.
// No dependencies.
`default_nettype none

package rqsc_pkg;

   localparam int unsigned Q_W     = 4;
   localparam int unsigned SLOT_W  = 16;
   localparam int unsigned ROUND_W = 32;
   localparam int unsigned EST_W   = 14;
   localparam int unsigned STEP_W  = 11;
   localparam int unsigned CSR_W   = 11;

   localparam logic [Q_W-1:0]    Q_MAX         = 4'd15;
   localparam logic [Q_W-1:0]    START_Q_RESET = 4'd4;
   localparam logic [STEP_W-1:0] STEP_C_RESET  = 11'd77;
   localparam logic [EST_W-1:0]  EST_RESET     = 14'(int'(START_Q_RESET) * 256);

   typedef enum logic [1:0] {
      CMD_ACK          = 2'd0,
      CMD_QUERY_REP    = 2'd1,
      CMD_QUERY_ADJUST = 2'd2,
      CMD_READ         = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OUT_IDLE       = 3'd0,
      OUT_RN16       = 3'd1,
      OUT_EPC_OK     = 3'd2,
      OUT_COLLISION  = 3'd3,
      OUT_HANDLE_OK  = 3'd4,
      OUT_HANDLE_BAD = 3'd5,
      OUT_READ_DONE  = 3'd6
   } outcome_type;

   localparam logic [2:0] UPDN_NONE = 3'd0;
   localparam logic [2:0] UPDN_DOWN = 3'd3;
   localparam logic [2:0] UPDN_UP   = 3'd6;

   typedef enum logic [0:0] {
      CSR_START_Q = 1'd0,
      CSR_STEP_C  = 1'd1
   } csr_index_type;

endpackage : rqsc_pkg

`default_nettype wire

/* rtl/core/rfid_q_slot_controller.sv */
// rfid_q_slot_controller: slot-by-slot Q control for a tag inventory.
// rsp_valid rises once an accepted req word passes the input register and the
// state update into the result register; one word per cycle with rsp_ready high.
// The estimate update, rounding, clamp and frame-end compare sit in one stage.
// Reset (synchronous, active high) restores Q = 4, estimate 4.0, slot 1, C = 77.
// Depends on rqsc_pkg.
`default_nettype none

module rfid_q_slot_controller (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [2:0]                      req_outcome,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [1:0]                           rsp_command,
   output logic [2:0]                           rsp_up_down,
   output logic [rqsc_pkg::Q_W-1:0]             rsp_q_now,
   output logic [rqsc_pkg::SLOT_W-1:0]          rsp_slot_now,
   output logic [rqsc_pkg::ROUND_W-1:0]         rsp_rounds_done,
   input  wire logic                            csr_wen,
   input  wire logic [0:0]                      csr_index,
   input  wire logic [rqsc_pkg::CSR_W-1:0]      csr_wdata
);
   import rqsc_pkg::*;

   logic                     in_valid_ff, in_valid_in;
   logic [2:0]               outcome_ff;
   logic                     out_valid_ff, out_valid_in;
   logic                     advance;

   logic [STEP_W-1:0]        step_c_ff;
   logic [EST_W-1:0]         est_ff, est_in;
   logic [Q_W-1:0]           q_target_ff, q_target_in;
   logic [Q_W-1:0]           q_current_ff, q_current_in;
   logic [SLOT_W-1:0]        slot_count_ff, slot_count_in;
   logic [2:0]               updn_ff, updn_in;
   logic [ROUND_W-1:0]       round_count_ff, round_count_in;
   cmd_type                  cmd_in;
   cmd_type                  cmd_ff;

   logic                     est_move;
   logic signed [EST_W:0]    delta;
   logic signed [EST_W:0]    est_sum;
   logic signed [EST_W-1:0]  est_sat;
   logic [EST_W-1:0]         est_round;
   logic [5:0]               est_whole;
   logic [Q_W-1:0]           target_new;
   logic [SLOT_W-1:0]        frame_len;
   logic                     close_slot;

   assign advance     = !out_valid_ff || rsp_ready;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = in_valid_ff ? 1'b1 : (advance ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         outcome_ff <= req_outcome;
      end
   end

   // drop start_q writes: it only shapes the reset value, which reset restores
   always_ff @(posedge clock) begin
      if (reset) begin
         step_c_ff <= STEP_C_RESET;
      end else if (csr_wen && csr_index == CSR_STEP_C) begin
         step_c_ff <= csr_wdata[STEP_W-1:0];
      end
   end

   always_comb begin
      est_move   = 1'b0;
      close_slot = 1'b1;
      cmd_in     = CMD_QUERY_REP;
      delta      = '0;
      case (outcome_ff)
         OUT_RN16: begin
            close_slot = 1'b0;
            cmd_in     = CMD_ACK;
         end
         OUT_HANDLE_OK: begin
            close_slot = 1'b0;
            cmd_in     = CMD_READ;
         end
         OUT_IDLE: begin
            est_move = 1'b1;
            delta    = -$signed({4'b0000, step_c_ff});
         end
         OUT_COLLISION: begin
            est_move = 1'b1;
            delta    = $signed({4'b0000, step_c_ff});
         end
         default: begin
            est_move = 1'b0;
         end
      endcase

      est_sum = $signed({est_ff[EST_W-1], est_ff}) + delta;
      if (est_sum < -15'sd8192) begin
         est_sat = 14'sh2000;
      end else if (est_sum > 15'sd8191) begin
         est_sat = 14'sd8191;
      end else begin
         est_sat = est_sum[EST_W-1:0];
      end

      est_round = est_sat[EST_W-1] ? '0 : ($unsigned(est_sat) + 14'd128);
      est_whole = est_round[EST_W-1:8];
      if (est_sat[EST_W-1]) begin
         target_new = '0;
      end else if (est_whole > {2'b00, Q_MAX}) begin
         target_new = Q_MAX;
      end else begin
         target_new = est_whole[Q_W-1:0];
      end

      est_in      = est_move ? $unsigned(est_sat) : est_ff;
      q_target_in = est_move ? target_new : q_target_ff;

      frame_len      = SLOT_W'(1) << q_current_ff;
      q_current_in   = q_current_ff;
      slot_count_in  = slot_count_ff;
      updn_in        = updn_ff;
      round_count_in = round_count_ff;
      if (close_slot) begin
         if (slot_count_ff == frame_len || q_current_ff != q_target_in) begin
            cmd_in = CMD_QUERY_ADJUST;
            if (q_target_in > q_current_ff) begin
               updn_in = UPDN_UP;
            end else if (q_target_in < q_current_ff) begin
               updn_in = UPDN_DOWN;
            end else begin
               updn_in = UPDN_NONE;
            end
            q_current_in   = q_target_in;
            slot_count_in  = SLOT_W'(1);
            round_count_in = round_count_ff + ROUND_W'(1);
         end else begin
            cmd_in        = CMD_QUERY_REP;
            slot_count_in = slot_count_ff + SLOT_W'(1);
         end
      end
   end

   // advance state and result together so the next word sees the update
   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff         <= EST_RESET;
         q_target_ff    <= START_Q_RESET;
         q_current_ff   <= START_Q_RESET;
         slot_count_ff  <= SLOT_W'(1);
         updn_ff        <= UPDN_NONE;
         round_count_ff <= '0;
      end else if (in_valid_ff && advance) begin
         est_ff         <= est_in;
         q_target_ff    <= q_target_in;
         q_current_ff   <= q_current_in;
         slot_count_ff  <= slot_count_in;
         updn_ff        <= updn_in;
         round_count_ff <= round_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         cmd_ff <= cmd_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_command     = cmd_ff;
   assign rsp_up_down     = updn_ff;
   assign rsp_q_now       = q_current_ff;
   assign rsp_slot_now    = slot_count_ff;
   assign rsp_rounds_done = round_count_ff;

   a_slot_nonzero: assert property (@(posedge clock) disable iff (reset)
      slot_count_ff != '0)
      else $error("slot count reached zero");

   a_adjust_restarts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_QUERY_ADJUST |->
         rsp_slot_now == SLOT_W'(1) && q_current_ff == q_target_ff)
      else $error("query adjust without frame restart");

   a_round_step: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && cmd_in == CMD_QUERY_ADJUST |=>
         round_count_ff == $past(round_count_ff) + ROUND_W'(1))
      else $error("round count did not step");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |=> $stable(slot_count_ff) && $stable(est_ff))
      else $error("state moved without a word");

endmodule : rfid_q_slot_controller

`default_nettype wire
